FILE: rtl/mmns_pkg.sv
// Package with shared types, constants and table functions of the note sequencer.
`timescale 1ns / 1ps
package mmns_pkg;

  // Parse modes of the command parser.
  localparam logic [3:0] MODE_IDLE    = 4'd0;
  localparam logic [3:0] MODE_NUM_T   = 4'd1;
  localparam logic [3:0] MODE_NUM_L   = 4'd2;
  localparam logic [3:0] MODE_NUM_N   = 4'd3;
  localparam logic [3:0] MODE_LEN_OPT = 4'd4;
  localparam logic [3:0] MODE_ACC     = 4'd5;
  localparam logic [3:0] MODE_OCT     = 4'd6;
  localparam logic [3:0] MODE_SKIP    = 4'd7;
  localparam logic [3:0] MODE_DONE    = 4'd8;

  // Character codes.
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_END   = 8'h0E;

  // Field widths.
  localparam int FREQ_W = 12;
  localparam int DUR_W  = 20;
  localparam int LEN_W  = 24;
  localparam int MULK_W = 18;
  localparam int PROD_W = MULK_W + LEN_W;
  localparam int ACC_W  = 16;

  localparam logic [MULK_W-1:0] MS_PER_BEAT_K = 18'd240000;
  localparam logic [7:0]        TEMPO_DEF     = 8'd120;
  localparam logic [2:0]        OCT_DEF       = 3'd4;
  localparam logic [2:0]        OCT_SOUND_MAX = 3'd6;

  // Semitone of each letter, A first.
  function automatic logic [3:0] letter_semi(input logic [2:0] l);
    logic [3:0] s;
    case (l)
      3'd0: s = 4'd9;
      3'd1: s = 4'd11;
      3'd2: s = 4'd0;
      3'd3: s = 4'd2;
      3'd4: s = 4'd4;
      3'd5: s = 4'd5;
      3'd6: s = 4'd7;
      default: s = 4'd9;
    endcase
    return s;
  endfunction

  // Letters that accept a sharp (not B, not E) or a flat (not C, not F).
  function automatic logic sharp_ok(input logic [2:0] l);
    return (l != 3'd1) && (l != 3'd4);
  endfunction

  function automatic logic flat_ok(input logic [2:0] l);
    return (l != 3'd2) && (l != 3'd5);
  endfunction

  // Equal-tempered pitch table, octave by semitone.
  localparam logic [FREQ_W-1:0] PITCH_TAB [0:6][0:11] = '{
    '{12'd33, 12'd35, 12'd37, 12'd39, 12'd41, 12'd44,
      12'd46, 12'd49, 12'd52, 12'd55, 12'd58, 12'd62},
    '{12'd66, 12'd69, 12'd73, 12'd78, 12'd82, 12'd87,
      12'd93, 12'd98, 12'd104, 12'd110, 12'd117, 12'd123},
    '{12'd131, 12'd139, 12'd147, 12'd156, 12'd165, 12'd175,
      12'd185, 12'd196, 12'd208, 12'd220, 12'd233, 12'd247},
    '{12'd262, 12'd277, 12'd294, 12'd311, 12'd330, 12'd349,
      12'd370, 12'd392, 12'd415, 12'd440, 12'd466, 12'd494},
    '{12'd523, 12'd554, 12'd587, 12'd622, 12'd659, 12'd698,
      12'd740, 12'd784, 12'd831, 12'd880, 12'd932, 12'd988},
    '{12'd1046, 12'd1108, 12'd1175, 12'd1245, 12'd1319, 12'd1397,
      12'd1480, 12'd1568, 12'd1661, 12'd1760, 12'd1865, 12'd1976},
    '{12'd2093, 12'd2217, 12'd2349, 12'd2489, 12'd2637, 12'd2794,
      12'd2960, 12'd3136, 12'd3322, 12'd3520, 12'd3729, 12'd3951}
  };

  // Pitch lookup; the semitone may run up to one octave above the letter.
  function automatic logic [FREQ_W-1:0] pitch_of(input logic [2:0] oct,
                                                 input logic [4:0] semi);
    logic [2:0] o;
    logic [4:0] s;
    o = (oct > OCT_SOUND_MAX) ? OCT_SOUND_MAX : oct;
    s = (semi >= 5'd12) ? semi - 5'd12 : semi;
    return PITCH_TAB[o][s[3:0]];
  endfunction

  // Handshake between the sequencer and the divider.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

FILE: rtl/mmns_if.sv
// Stream interfaces for the character input and the tone result channels.
`timescale 1ns / 1ps
interface mmns_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_string;

  modport source (output valid, output char_code, output end_of_string, input ready);
  modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

interface mmns_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] tone_freq;
  logic [19:0] duration_ms;
  logic        last_of_run;

  modport source (output valid, output tone_freq, output duration_ms,
                  output last_of_run, input ready);
  modport sink   (input valid, input tone_freq, input duration_ms,
                  input last_of_run, output ready);
endinterface

FILE: rtl/mmns_div.sv
// Radix-2 restoring divider shared by the length reciprocal and the note duration.
`timescale 1ns / 1ps
module mmns_div #(
  parameter int DW = 42,
  parameter int VW = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mmns_pkg::div_ctl_t    ctl,
  input  logic [DW-1:0]         dividend,
  input  logic [VW-1:0]         divisor,
  output mmns_pkg::div_sts_t    sts,
  output logic [DW-1:0]         quotient
);
  import mmns_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] dq_r;
  logic [VW-1:0] rem_r;
  logic [VW-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          fits;

  // One quotient bit per cycle.
  assign trial = {rem_r, dq_r[DW-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DW);
        dq_r   <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= fits ? diff[VW-1:0] : trial[VW-1:0];
        dq_r  <= {dq_r[DW-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = dq_r;

endmodule

FILE: rtl/music_macro_note_sequencer_core.sv
// Top level of the music macro note sequencer: parser, sequencer and result register.
`timescale 1ns / 1ps
// The block reads a music string one character per input transaction and
// produces tone results (frequency in Hz, hold time in ms). A character that
// ends a pending note or rest runs the shared 42-step serial divider that
// turns tempo and length into milliseconds; a length number (L or a note
// length) adds another divider pass for the reciprocal. The input is not
// ready while a character is being worked on, and each result waits for the
// output register to be free. Clearing register sound_enable at address 0
// forces tone frequencies to zero.
module music_macro_note_sequencer_core #(
  parameter int NUM_OCTAVES      = 7,
  parameter int LENGTH_FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  mmns_in_if.sink     in_ch,
  mmns_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mmns_pkg::*;

  localparam int                DW      = PROD_W;
  localparam int                VW      = ACC_W;
  localparam logic [2:0]        OCT_MAX = 3'(NUM_OCTAVES - 1);
  localparam logic [2:0]        OCT_RST = (OCT_DEF > OCT_MAX) ? OCT_MAX : OCT_DEF;
  localparam logic [LEN_W-1:0]  LEN_ONE = LEN_W'(1) << LENGTH_FRAC_BITS;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PARSE  = 4'd1;
  localparam logic [3:0] S_RECIP  = 4'd2;
  localparam logic [3:0] S_FCHK   = 4'd3;
  localparam logic [3:0] S_MUL    = 4'd4;
  localparam logic [3:0] S_DSTART = 4'd5;
  localparam logic [3:0] S_DWAIT  = 4'd6;
  localparam logic [3:0] S_TONE   = 4'd7;
  localparam logic [3:0] S_SIL    = 4'd8;
  localparam logic [3:0] S_TERM   = 4'd9;
  localparam logic [3:0] S_POST   = 4'd10;

  logic [3:0]        st_r;
  logic [3:0]        mode_r;
  logic [ACC_W-1:0]  accum_r;
  logic [7:0]        tempo_r;
  logic [LEN_W-1:0]  base_len_r;
  logic [LEN_W-1:0]  note_len_r;
  logic [2:0]        oct_r;
  logic [FREQ_W-1:0] pend_freq_r;
  logic              have_pend_r;
  logic [2:0]        letter_r;
  logic [7:0]        ch_r;
  logic              eos_r;
  logic              eos_phase_r;
  logic              flushed_r;
  logic              sound_en_r;
  logic [PROD_W-1:0] prod_r;
  logic [DW-1:0]     d_r;
  logic              div_start_r;
  logic [DW-1:0]     div_a_r;
  logic [VW-1:0]     div_b_r;
  logic              out_valid_r;
  logic [FREQ_W-1:0] out_freq_r;
  logic [DUR_W-1:0]  out_dur_r;
  logic              out_last_r;

  div_ctl_t          div_ctl;
  div_sts_t          div_sts;
  logic [DW-1:0]     div_q;

  // Character classes and derived values.
  logic              is_dig;
  logic [3:0]        dig_val;
  logic              is_letter;
  logic [2:0]        ch_letter;
  logic [ACC_W+3:0]  acc_sum;
  logic [ACC_W-1:0]  acc_sat;
  logic [7:0]        tempo_sat;
  logic [LEN_W:0]    dot_sum;
  logic [LEN_W-1:0]  dot_sat;
  logic [4:0]        semi_cur;
  logic [2:0]        oct_digit;
  logic [7:0]        tempo_eff;
  logic [DW+2:0]     d_times7;
  logic [DW-1:0]     d_tone;
  logic [DW-1:0]     d_sil;
  logic [DUR_W-1:0]  dur_tone;
  logic [DUR_W-1:0]  dur_sil;
  logic              out_free;
  logic              cfg_wr;

  assign is_dig    = (ch_r >= CH_0) && (ch_r <= CH_9);
  assign dig_val   = is_dig ? 4'(ch_r - CH_0) : 4'd0;
  assign is_letter = (ch_r >= CH_A) && (ch_r <= CH_G);
  assign ch_letter = 3'(ch_r - CH_A);
  assign acc_sum   = ({4'd0, accum_r} << 3) + ({4'd0, accum_r} << 1) + (ACC_W+4)'(dig_val);
  assign acc_sat   = (|acc_sum[ACC_W+3:ACC_W]) ? '1 : acc_sum[ACC_W-1:0];
  assign tempo_sat = (|accum_r[ACC_W-1:8]) ? 8'hFF : accum_r[7:0];
  assign dot_sum   = {1'b0, note_len_r} + {2'b0, note_len_r[LEN_W-1:1]};
  assign dot_sat   = dot_sum[LEN_W] ? '1 : dot_sum[LEN_W-1:0];
  assign semi_cur  = {1'b0, letter_semi(letter_r)};
  assign oct_digit = ((ch_r >= CH_0) && (ch_r <= CH_7)) ? ch_r[2:0] : OCT_DEF;
  assign tempo_eff = (tempo_r == 8'd0) ? TEMPO_DEF : tempo_r;

  // Tone takes 7/8 and silence 1/8 of the note duration, each saturating.
  assign d_times7  = {d_r, 3'b000} - {3'b000, d_r};
  assign d_tone    = d_times7[DW+2:3];
  assign d_sil     = d_r >> 3;
  assign dur_tone  = (|d_tone[DW-1:DUR_W]) ? '1 : d_tone[DUR_W-1:0];
  assign dur_sil   = (|d_sil[DW-1:DUR_W]) ? '1 : d_sil[DUR_W-1:0];

  assign out_free  = !out_valid_r || out_ch.ready;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {31'd0, sound_en_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sound_en_r <= 1'b1;
    end else if (cfg_wr) begin
      sound_en_r <= cfg_pwdata[0];
    end
  end

  // Shared divider.
  assign div_ctl.start = div_start_r;

  mmns_div #(
    .DW(DW),
    .VW(VW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_a_r),
    .divisor  (div_b_r),
    .sts      (div_sts),
    .quotient (div_q)
  );

  // Main sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      mode_r      <= MODE_IDLE;
      accum_r     <= '0;
      tempo_r     <= TEMPO_DEF;
      base_len_r  <= LEN_ONE;
      note_len_r  <= LEN_ONE;
      oct_r       <= OCT_RST;
      pend_freq_r <= '0;
      have_pend_r <= 1'b0;
      letter_r    <= '0;
      eos_phase_r <= 1'b0;
      flushed_r   <= 1'b0;
      div_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      div_start_r <= 1'b0;
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            ch_r        <= in_ch.char_code;
            eos_r       <= in_ch.end_of_string;
            eos_phase_r <= 1'b0;
            flushed_r   <= 1'b0;
            st_r        <= S_PARSE;
          end
        end

        S_PARSE: begin
          case (mode_r)
            MODE_NUM_T, MODE_NUM_L, MODE_NUM_N: begin
              if (is_dig) begin
                accum_r <= acc_sat;
                st_r    <= S_POST;
              end else if (mode_r == MODE_NUM_T) begin
                tempo_r <= tempo_sat;
                mode_r  <= MODE_IDLE;
              end else if (accum_r == '0) begin
                if (mode_r == MODE_NUM_L) begin
                  base_len_r <= LEN_ONE;
                end
                note_len_r <= LEN_ONE;
                mode_r     <= MODE_IDLE;
              end else begin
                div_a_r     <= DW'(LEN_ONE);
                div_b_r     <= accum_r;
                div_start_r <= 1'b1;
                st_r        <= S_RECIP;
              end
            end
            MODE_LEN_OPT: begin
              if (is_dig) begin
                accum_r <= ACC_W'(dig_val);
                mode_r  <= MODE_NUM_N;
                st_r    <= S_POST;
              end else begin
                mode_r <= MODE_IDLE;
              end
            end
            MODE_ACC: begin
              mode_r <= MODE_LEN_OPT;
              if (((ch_r == CH_HASH) || (ch_r == CH_PLUS)) && sharp_ok(letter_r)) begin
                pend_freq_r <= pitch_of(oct_r, semi_cur + 5'd1);
                st_r        <= S_POST;
              end else if ((ch_r == CH_MINUS) && flat_ok(letter_r)) begin
                pend_freq_r <= pitch_of(oct_r, semi_cur + 5'd11);
                st_r        <= S_POST;
              end
            end
            MODE_OCT: begin
              oct_r  <= (oct_digit > OCT_MAX) ? OCT_MAX : oct_digit;
              mode_r <= MODE_IDLE;
              st_r   <= S_POST;
            end
            MODE_SKIP: begin
              mode_r <= MODE_IDLE;
              st_r   <= S_POST;
            end
            MODE_DONE: begin
              st_r <= S_POST;
            end
            default: begin
              // Command dispatch; notes, rests and the end code first close
              // out the pending note.
              mode_r <= MODE_IDLE;
              if ((is_letter || (ch_r == CH_P) || (ch_r == CH_END)) &&
                  have_pend_r && !flushed_r) begin
                st_r <= S_MUL;
              end else begin
                st_r <= S_POST;
                if (is_letter) begin
                  letter_r    <= ch_letter;
                  pend_freq_r <= pitch_of(oct_r, {1'b0, letter_semi(ch_letter)});
                  have_pend_r <= 1'b1;
                  mode_r      <= MODE_ACC;
                end else begin
                  case (ch_r)
                    CH_T: begin
                      accum_r <= '0;
                      mode_r  <= MODE_NUM_T;
                    end
                    CH_L: begin
                      accum_r <= '0;
                      mode_r  <= MODE_NUM_L;
                    end
                    CH_O: mode_r <= MODE_OCT;
                    CH_M: mode_r <= MODE_SKIP;
                    CH_LT: begin
                      if (oct_r > 3'd0) oct_r <= oct_r - 3'd1;
                    end
                    CH_GT: begin
                      if (oct_r < OCT_MAX) oct_r <= oct_r + 3'd1;
                    end
                    CH_DOT: note_len_r <= dot_sat;
                    CH_P: begin
                      pend_freq_r <= '0;
                      have_pend_r <= 1'b1;
                      mode_r      <= MODE_LEN_OPT;
                    end
                    CH_END: st_r <= S_TERM;
                    default: ;
                  endcase
                end
              end
            end
          endcase
        end

        S_RECIP: begin
          if (div_sts.done) begin
            if (mode_r == MODE_NUM_L) begin
              base_len_r <= div_q[LEN_W-1:0];
            end
            note_len_r <= div_q[LEN_W-1:0];
            mode_r     <= MODE_IDLE;
            st_r       <= eos_phase_r ? S_FCHK : S_PARSE;
          end
        end

        S_FCHK: begin
          st_r <= have_pend_r ? S_MUL : S_TERM;
        end

        S_MUL: begin
          prod_r <= PROD_W'(MS_PER_BEAT_K * note_len_r);
          st_r   <= S_DSTART;
        end

        S_DSTART: begin
          div_a_r     <= prod_r >> LENGTH_FRAC_BITS;
          div_b_r     <= VW'(tempo_eff);
          div_start_r <= 1'b1;
          st_r        <= S_DWAIT;
        end

        S_DWAIT: begin
          if (div_sts.done) begin
            d_r  <= div_q;
            st_r <= S_TONE;
          end
        end

        S_TONE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_freq_r  <= sound_en_r ? pend_freq_r : '0;
            out_dur_r   <= dur_tone;
            out_last_r  <= 1'b0;
            st_r        <= S_SIL;
          end
        end

        S_SIL: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_freq_r  <= '0;
            out_dur_r   <= dur_sil;
            // A terminating result follows at the end of the string or code 14.
            out_last_r  <= !eos_phase_r && !eos_r && (ch_r != CH_END);
            note_len_r  <= base_len_r;
            if (eos_phase_r) begin
              st_r <= S_TERM;
            end else begin
              flushed_r <= 1'b1;
              st_r      <= S_PARSE;
            end
          end
        end

        S_TERM: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_freq_r  <= '0;
            out_dur_r   <= '0;
            out_last_r  <= 1'b1;
            if (eos_phase_r) begin
              mode_r      <= MODE_IDLE;
              accum_r     <= '0;
              tempo_r     <= TEMPO_DEF;
              base_len_r  <= LEN_ONE;
              note_len_r  <= LEN_ONE;
              oct_r       <= OCT_RST;
              pend_freq_r <= '0;
              have_pend_r <= 1'b0;
              letter_r    <= '0;
              st_r        <= S_IDLE;
            end else begin
              mode_r <= MODE_DONE;
              st_r   <= S_POST;
            end
          end
        end

        S_POST: begin
          if (!eos_r) begin
            st_r <= S_IDLE;
          end else begin
            eos_phase_r <= 1'b1;
            if (mode_r == MODE_DONE) begin
              // String already terminated: only return to start values.
              mode_r      <= MODE_IDLE;
              accum_r     <= '0;
              tempo_r     <= TEMPO_DEF;
              base_len_r  <= LEN_ONE;
              note_len_r  <= LEN_ONE;
              oct_r       <= OCT_RST;
              pend_freq_r <= '0;
              have_pend_r <= 1'b0;
              letter_r    <= '0;
              st_r        <= S_IDLE;
            end else if (mode_r == MODE_NUM_T) begin
              tempo_r <= tempo_sat;
              mode_r  <= MODE_IDLE;
              st_r    <= S_FCHK;
            end else if ((mode_r == MODE_NUM_L) || (mode_r == MODE_NUM_N)) begin
              if (accum_r == '0) begin
                if (mode_r == MODE_NUM_L) begin
                  base_len_r <= LEN_ONE;
                end
                note_len_r <= LEN_ONE;
                mode_r     <= MODE_IDLE;
                st_r       <= S_FCHK;
              end else begin
                div_a_r     <= DW'(LEN_ONE);
                div_b_r     <= accum_r;
                div_start_r <= 1'b1;
                st_r        <= S_RECIP;
              end
            end else begin
              mode_r <= MODE_IDLE;
              st_r   <= S_FCHK;
            end
          end
        end

        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready        = (st_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.tone_freq   = out_freq_r;
  assign out_ch.duration_ms = out_dur_r;
  assign out_ch.last_of_run = out_last_r;

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench of the music macro note sequencer core.
`timescale 1ns / 1ps
module testbench;
  import mmns_pkg::*;

  localparam int IDLE_LIMIT  = 20000;
  localparam int SETTLE_CYC  = 200;
  localparam int HOLD_CYC    = 400;
  localparam int RAND_ITEMS  = 440;
  localparam logic [1:0] ADDR_SOUND_ENABLE = 2'd0;
  // Letter indexes, A first.
  localparam int LTR_B = 1;
  localparam int LTR_C = 2;
  localparam int LTR_E = 4;
  localparam int LTR_F = 5;
  localparam int unsigned NOTE_SEMI [0:6] = '{9, 11, 0, 2, 4, 5, 7};

  typedef struct {
    logic [11:0] freq;
    logic [19:0] dur;
    logic        last;
  } tone_t;

  typedef struct {
    logic [7:0] c;
    logic       eos;
    bit         typed;
    tone_t      want;
  } row_t;

  logic clk;
  logic rst_n;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [1:0]  cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic        cfg_pready;

  mmns_in_if  in_if ();
  mmns_out_if out_if ();

  music_macro_note_sequencer_core u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_if), .out_ch(out_if),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  tone_t tones_due[$];
  tone_t step_tones[$];
  int    errs;
  int    tones_seen;
  bit    calm;
  bit    held;

  // Predictor state for the string parser.
  logic [3:0]  p_mode;
  int unsigned p_acc, p_tempo, p_base, p_len, p_oct, p_freq, p_letter;
  bit          p_have, p_snd;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function void restart_string();
    p_mode = MODE_IDLE;
    p_acc = 0;
    p_tempo = 120;
    p_base = 1 << 16;
    p_len = p_base;
    p_oct = 4;
    p_freq = 0;
    p_have = 0;
    p_letter = 0;
  endfunction

  function int unsigned pitch(input int unsigned semi);
    int unsigned o;
    o = (p_oct > 6) ? 6 : p_oct;
    return 32'(PITCH_TAB[o][semi % 12]);
  endfunction

  function int unsigned reciprocal(input int unsigned n);
    return (n == 0) ? (1 << 16) : ((1 << 16) / n);
  endfunction

  function void add_tone(input int unsigned f, input longint unsigned d);
    tone_t t;
    if (step_tones.size() >= 5) return;
    t.freq = p_snd ? f[11:0] : 12'd0;
    t.dur  = (d > 64'hFFFFF) ? 20'hFFFFF : d[19:0];
    t.last = 1'b0;
    step_tones.push_back(t);
  endfunction

  // A pending note splits into a 7/8 tone and a 1/8 silence.
  function void play_pending();
    longint unsigned t, d;
    if (!p_have) return;
    t = (p_tempo == 0) ? 64'd120 : 64'(p_tempo);
    d = (64'd240000 * p_len) / (t << 16);
    add_tone(p_freq, (d * 7) / 8);
    add_tone(0, d / 8);
    p_len = p_base;
  endfunction

  function void close_number();
    case (p_mode)
      MODE_NUM_T: p_tempo = (p_acc > 255) ? 255 : p_acc;
      MODE_NUM_L: begin
        p_base = reciprocal(p_acc);
        p_len = p_base;
      end
      MODE_NUM_N: p_len = reciprocal(p_acc);
      default: ;
    endcase
    p_mode = MODE_IDLE;
  endfunction

  function void run_command(input logic [7:0] c);
    longint unsigned v;
    if (c >= CH_A && c <= CH_G) begin
      play_pending();
      p_letter = 32'(c - CH_A);
      p_freq = pitch(NOTE_SEMI[p_letter]);
      p_have = 1;
      p_mode = MODE_ACC;
    end else begin
      case (c)
        CH_T: begin p_acc = 0; p_mode = MODE_NUM_T; end
        CH_L: begin p_acc = 0; p_mode = MODE_NUM_L; end
        CH_O: p_mode = MODE_OCT;
        CH_M: p_mode = MODE_SKIP;
        CH_LT: if (p_oct > 0) p_oct--;
        CH_GT: if (p_oct < 6) p_oct++;
        CH_DOT: begin
          v = (64'(p_len) * 3) / 2;
          p_len = (v > 64'hFFFFFF) ? 32'hFFFFFF : v[31:0];
        end
        CH_P: begin
          play_pending();
          p_freq = 0;
          p_have = 1;
          p_mode = MODE_LEN_OPT;
        end
        CH_END: begin
          play_pending();
          add_tone(0, 0);
          p_mode = MODE_DONE;
        end
        default: ;
      endcase
    end
  endfunction

  // A character may close a number and then be taken again as a command.
  function void take_char(input logic [7:0] c);
    bit dig, fin;
    int unsigned d, s;
    dig = (c >= CH_0 && c <= CH_9);
    d = dig ? 32'(c - CH_0) : 0;
    fin = 0;
    while (!fin) begin
      case (p_mode)
        MODE_NUM_T, MODE_NUM_L, MODE_NUM_N: begin
          if (dig) begin
            s = p_acc * 10 + d;
            p_acc = (s > 65535) ? 65535 : s;
            fin = 1;
          end else begin
            close_number();
          end
        end
        MODE_LEN_OPT: begin
          if (dig) begin
            p_acc = d;
            p_mode = MODE_NUM_N;
            fin = 1;
          end else begin
            p_mode = MODE_IDLE;
          end
        end
        MODE_ACC: begin
          s = NOTE_SEMI[p_letter];
          p_mode = MODE_LEN_OPT;
          if ((c == CH_HASH || c == CH_PLUS) && p_letter != LTR_B && p_letter != LTR_E) begin
            p_freq = pitch(s + 1);
            fin = 1;
          end else if (c == CH_MINUS && p_letter != LTR_C && p_letter != LTR_F) begin
            p_freq = pitch(s + 11);
            fin = 1;
          end
        end
        MODE_OCT: begin
          p_oct = (c >= CH_0 && c <= CH_7) ? d : 4;
          if (p_oct > 6) p_oct = 6;
          p_mode = MODE_IDLE;
          fin = 1;
        end
        MODE_SKIP: begin
          p_mode = MODE_IDLE;
          fin = 1;
        end
        MODE_DONE: fin = 1;
        default: begin
          p_mode = MODE_IDLE;
          run_command(c);
          fin = 1;
        end
      endcase
    end
  endfunction

  function void predict_char(input logic [7:0] c, input logic eos);
    step_tones.delete();
    take_char(c);
    if (eos) begin
      if (p_mode != MODE_DONE) begin
        close_number();
        play_pending();
        add_tone(0, 0);
      end
      restart_string();
    end
    if (step_tones.size() > 0) step_tones[step_tones.size() - 1].last = 1'b1;
  endfunction

  // Offer one character and book its expected tones once it is taken.
  task automatic send_char(input row_t r);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.char_code <= r.c;
    in_if.end_of_string <= r.eos;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    predict_char(r.c, r.eos);
    if (r.typed) begin
      step_tones.delete();
      step_tones.push_back(r.want);
    end
    foreach (step_tones[i]) tones_due.push_back(step_tones[i]);
  endtask

  task automatic write_sound_enable(input logic v);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_SOUND_ENABLE;
    cfg_pwdata <= {31'd0, v};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    p_snd = v;
  endtask

  // Wait for every booked tone, then let a character without tones finish.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (tones_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  function automatic void add_digits(ref logic [7:0] s[$], input int n);
    for (int i = 0; i < n; i++) s.push_back(8'(CH_0 + $urandom_range(0, 9)));
  endfunction

  // One well-formed music string with random content, rarely broken by noise.
  function automatic void make_string(ref logic [7:0] s[$]);
    int toks;
    toks = $urandom_range(1, 8);
    for (int k = 0; k < toks; k++) begin
      case ($urandom_range(0, 15))
        0, 1, 2, 3: begin
          s.push_back(8'(CH_A + $urandom_range(0, 6)));
          case ($urandom_range(0, 3))
            0: s.push_back(CH_HASH);
            1: s.push_back(CH_PLUS);
            2: s.push_back(CH_MINUS);
            default: ;
          endcase
          add_digits(s, $urandom_range(0, 2));
        end
        4: begin s.push_back(CH_T); add_digits(s, $urandom_range(0, 6)); end
        5: begin s.push_back(CH_L); add_digits(s, $urandom_range(0, 3)); end
        6: begin s.push_back(CH_O); s.push_back(8'(CH_0 + $urandom_range(0, 10))); end
        7: s.push_back(CH_LT);
        8: s.push_back(CH_GT);
        9: repeat ($urandom_range(1, 24)) s.push_back(CH_DOT);
        10: begin s.push_back(CH_P); add_digits(s, $urandom_range(0, 2)); end
        11: begin s.push_back(CH_M); s.push_back(8'($urandom_range(0, 255))); end
        12: if ($urandom_range(0, 3) == 0) s.push_back(CH_END);
        13: s.push_back(8'($urandom_range(0, 255)));
        default: add_digits(s, 1);
      endcase
    end
  endfunction

  task automatic random_phase(input int items);
    logic [7:0] s[$];
    row_t r;
    int sent;
    sent = 0;
    r.typed = 0;
    while (sent < items) begin
      calm = ($urandom_range(0, 4) == 0);
      s.delete();
      make_string(s);
      foreach (s[i]) begin
        r.c = s[i];
        r.eos = (i == s.size() - 1);
        send_char(r);
        sent++;
      end
    end
    calm = 0;
  endtask

  // Directed strings: edge values of every command but >, and the corrections.
  row_t rows [] = '{
    '{CH_END, 1'b0, 1'b1, '{12'd0, 20'd0, 1'b1}},
    '{8'hFF,  1'b1, 1'b0, '{0, 0, 0}},
    '{CH_T,   1'b0, 1'b0, '{0, 0, 0}},
    '{CH_0,   1'b0, 1'b0, '{0, 0, 0}},
    '{CH_O,   1'b0, 1'b0, '{0, 0, 0}},
    '{CH_7,   1'b0, 1'b0, '{0, 0, 0}},
    '{CH_A,   1'b0, 1'b0, '{0, 0, 0}},
    '{CH_HASH, 1'b0, 1'b0, '{0, 0, 0}},
    '{CH_DOT, 1'b0, 1'b0, '{0, 0, 0}},
    '{CH_L,   1'b0, 1'b0, '{0, 0, 0}},
    '{CH_P,   1'b0, 1'b0, '{0, 0, 0}},
    '{CH_M,   1'b0, 1'b0, '{0, 0, 0}},
    '{CH_O,   1'b0, 1'b0, '{0, 0, 0}},
    '{CH_9,   1'b0, 1'b0, '{0, 0, 0}},
    '{8'h42,  1'b0, 1'b0, '{0, 0, 0}},
    '{CH_HASH, 1'b0, 1'b0, '{0, 0, 0}},
    '{8'h43,  1'b0, 1'b0, '{0, 0, 0}},
    '{CH_MINUS, 1'b0, 1'b0, '{0, 0, 0}},
    '{8'h45,  1'b0, 1'b0, '{0, 0, 0}},
    '{CH_PLUS, 1'b0, 1'b0, '{0, 0, 0}},
    '{CH_O,   1'b0, 1'b0, '{0, 0, 0}},
    '{CH_0,   1'b0, 1'b0, '{0, 0, 0}},
    '{CH_LT,  1'b0, 1'b0, '{0, 0, 0}},
    '{8'h46,  1'b0, 1'b0, '{0, 0, 0}},
    '{CH_T,   1'b0, 1'b0, '{0, 0, 0}},
    '{CH_9,   1'b1, 1'b0, '{0, 0, 0}}
  };

  // Result side: random stalls, one long hold-off to back the block up.
  initial begin
    int stall;
    out_if.ready = 1'b0;
    held = 0;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (!held && tones_seen >= 60) begin
        held = 1;
        stall = HOLD_CYC;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
    end
  end

  // Compare each tone transaction with the oldest booked one.
  always @(posedge clk) begin
    tone_t w;
    if (rst_n && out_if.valid && out_if.ready) begin
      tones_seen++;
      if (tones_due.size() == 0) begin
        $error("unexpected tone freq=%0d dur=%0d", out_if.tone_freq, out_if.duration_ms);
        errs++;
      end else begin
        w = tones_due.pop_front();
        if (out_if.tone_freq !== w.freq) begin
          $error("tone_freq expected %0d actual %0d", w.freq, out_if.tone_freq);
          errs++;
        end
        if (out_if.duration_ms !== w.dur) begin
          $error("duration_ms expected %0d actual %0d", w.dur, out_if.duration_ms);
          errs++;
        end
        if (out_if.last_of_run !== w.last) begin
          $error("last_of_run expected %0d actual %0d", w.last, out_if.last_of_run);
          errs++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk) begin
    int quiet;
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_psel && cfg_penable)) begin
      quiet = 0;
    end else begin
      quiet++;
    end
    if (quiet >= IDLE_LIMIT) begin
      $display("music_macro_note_sequencer_core regression: fail");
      $finish;
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    errs = 0;
    tones_seen = 0;
    calm = 0;
    in_if.valid = 1'b0;
    in_if.char_code = 8'd0;
    in_if.end_of_string = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = 2'd0;
    cfg_pwdata = 32'd0;
    p_snd = 1;
    restart_string();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_char(rows[i]);
    drain();

    write_sound_enable(1'b0);
    random_phase(RAND_ITEMS / 4);
    drain();

    write_sound_enable(1'b1);
    random_phase(RAND_ITEMS - RAND_ITEMS / 4);
    drain();

    if (errs == 0) begin
      $display("music_macro_note_sequencer_core regression: pass");
    end else begin
      $display("music_macro_note_sequencer_core regression: fail");
    end
    $finish;
  end

endmodule
